>>> hdl/rgm_pkg.sv
// rgm_pkg: shared types, constants and the arctangent table for the
// roberts gradient block; used by every module under hdl
package rgm_pkg;

  localparam int MaxWidth    = 2048;
  localparam int SampleBits  = 16;
  localparam int AddrBits    = $clog2(MaxWidth);
  localparam int DimBits     = 12;
  localparam int DiffBits    = SampleBits + 1;
  localparam int MagBits     = 17;
  localparam int AngBits     = 16;
  localparam int CordicSteps = 24;
  localparam int SqrtSteps   = 17;
  localparam int StepBits    = 5;
  localparam int VecBits     = 34;
  localparam int ZBits       = 28;
  localparam int SumBits     = 35;

  localparam logic signed [ZBits-1:0] PiQ24 = 28'sd52707179;
  localparam logic signed [17:0] QuarterPiQ13 = 18'sd6434;
  localparam logic signed [17:0] PiQ13        = 18'sd25736;
  localparam logic signed [17:0] TwoPiQ13     = 18'sd51472;

  localparam logic [DimBits-1:0] WidthReset  = 12'd640;
  localparam logic [DimBits-1:0] HeightReset = 12'd480;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [DimBits-1:0] width;
    logic [DimBits-1:0] height;
  } dims_t;

  // one classified window between front and back
  typedef struct packed {
    logic signed [DiffBits-1:0] d1;
    logic signed [DiffBits-1:0] d2;
    logic                       und;
    logic [AddrBits-1:0]        col;
    logic [AddrBits-1:0]        row;
    logic                       last;
  } win_t;

  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;

  function automatic logic signed [ZBits-1:0] atan_q24(input logic [StepBits-1:0] i);
    logic signed [ZBits-1:0] v;
    case (i)
      5'd0:  v = 28'sd13176795;
      5'd1:  v = 28'sd7778716;
      5'd2:  v = 28'sd4110060;
      5'd3:  v = 28'sd2086331;
      5'd4:  v = 28'sd1047214;
      5'd5:  v = 28'sd524117;
      5'd6:  v = 28'sd262123;
      5'd7:  v = 28'sd131069;
      5'd8:  v = 28'sd65536;
      5'd9:  v = 28'sd32768;
      5'd10: v = 28'sd16384;
      5'd11: v = 28'sd8192;
      5'd12: v = 28'sd4096;
      5'd13: v = 28'sd2048;
      5'd14: v = 28'sd1024;
      5'd15: v = 28'sd512;
      5'd16: v = 28'sd256;
      5'd17: v = 28'sd128;
      5'd18: v = 28'sd64;
      5'd19: v = 28'sd32;
      5'd20: v = 28'sd16;
      5'd21: v = 28'sd8;
      5'd22: v = 28'sd4;
      5'd23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/rgm_if.sv
// rgm_if: valid/ready channel interfaces for pixels and results
// depends on rgm_pkg for field widths
interface rgm_pix_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [rgm_pkg::SampleBits-1:0]  sample;
  logic                                   sample_undefined;
  modport source (output valid, output sample, output sample_undefined, input ready);
  modport sink   (input valid, input sample, input sample_undefined, output ready);
endinterface

interface rgm_res_if;
  logic                                valid;
  logic                                ready;
  logic [rgm_pkg::MagBits-1:0]         magnitude;
  logic signed [rgm_pkg::AngBits-1:0]  angle;
  logic                                result_undefined;
  logic [rgm_pkg::AddrBits-1:0]        column;
  logic [rgm_pkg::AddrBits-1:0]        row;
  logic                                frame_last;
  modport source (output valid, output magnitude, output angle, output result_undefined,
                  output column, output row, output frame_last, input ready);
  modport sink   (input valid, input magnitude, input angle, input result_undefined,
                  input column, input row, input frame_last, output ready);
endinterface

>>> hdl/rgm_front.sv
// rgm_front: raster counters, line store and 2x2 window, forms the two
// diagonal differences and pushes windows to the queue; uses rgm_pkg
module rgm_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rgm_pkg::dims_t        dims_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [rgm_pkg::SampleBits-1:0] sample_i,
  input  logic                  sample_undefined_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output rgm_pkg::win_t         q_item_o
);

  typedef enum logic {
    F_IDLE,
    F_WRITE
  } fstate_e;

  localparam int PixBits  = rgm_pkg::SampleBits + 1;
  localparam int DiffBits = rgm_pkg::DiffBits;

  fstate_e                       state_q, state_d;
  logic [PixBits-1:0]            mem [rgm_pkg::MaxWidth];
  logic [PixBits-1:0]            upper_q;
  logic [PixBits-1:0]            cur_q, cur_d;
  logic [PixBits-1:0]            left_q, left_d, ul_q, ul_d;
  logic [rgm_pkg::AddrBits-1:0]  col_q, col_d, row_q, row_d;
  logic [rgm_pkg::DimBits-1:0]   w, h;
  logic                          accept, emit, done, last_col, last_row;

  always_comb begin
    w = dims_i.width;
    if (w < 12'd2) w = 12'd2;
    else if (w > 12'(rgm_pkg::MaxWidth)) w = 12'(rgm_pkg::MaxWidth);
    h = dims_i.height;
    if (h < 12'd2) h = 12'd2;
    else if (h > 12'(rgm_pkg::MaxWidth)) h = 12'(rgm_pkg::MaxWidth);
  end

  assign in_ready_o = (state_q == F_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign last_col   = ({1'b0, col_q} + 12'd1) >= w;
  assign last_row   = ({1'b0, row_q} + 12'd1) >= h;
  assign emit       = (col_q != '0) && (row_q != '0);
  assign done       = (state_q == F_WRITE) && (!emit || !q_full_i);
  assign q_push_o   = done && emit;

  always_comb begin
    q_item_o.d1   = DiffBits'($signed(cur_q[PixBits-2:0]))
                    - DiffBits'($signed(ul_q[PixBits-2:0]));
    q_item_o.d2   = DiffBits'($signed(upper_q[PixBits-2:0]))
                    - DiffBits'($signed(left_q[PixBits-2:0]));
    q_item_o.und  = cur_q[PixBits-1] | ul_q[PixBits-1] | upper_q[PixBits-1]
                    | left_q[PixBits-1];
    q_item_o.col  = col_q - 1'b1;
    q_item_o.row  = row_q - 1'b1;
    q_item_o.last = last_col && last_row;
  end

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    left_d  = left_q;
    ul_d    = ul_q;
    col_d   = col_q;
    row_d   = row_q;
    if (accept) begin
      cur_d   = {sample_undefined_i, sample_i};
      state_d = F_WRITE;
    end
    if (done) begin
      ul_d    = upper_q;
      left_d  = cur_q;
      state_d = F_IDLE;
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  // line store: read on accept, written back when the window leaves
  always_ff @(posedge clk_i) begin
    if (accept) upper_q <= mem[col_q];
    if (done) mem[col_q] <= cur_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cur_q   <= '0;
      left_q  <= '0;
      ul_q    <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      left_q  <= left_d;
      ul_q    <= ul_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

endmodule

>>> hdl/rgm_queue.sv
// rgm_queue: two-entry window queue between front and back
// uses rgm_pkg::win_t and rgm_pkg::qctl_t
module rgm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rgm_pkg::qctl_t wr_i,
  output logic           full_o,
  input  rgm_pkg::win_t  item_i,
  input  logic           pop_i,
  output logic           empty_o,
  output rgm_pkg::win_t  item_o
);

  rgm_pkg::win_t buf_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i.push) buf_q[wp_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_i.push) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr_i.push} - {1'b0, pop_i};
    end
  end

endmodule

>>> hdl/rgm_back.sv
// rgm_back: iterative square root and cordic vectoring over one window,
// holds the result register; uses rgm_pkg
module rgm_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  output logic          q_pop_o,
  input  rgm_pkg::win_t q_item_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [rgm_pkg::MagBits-1:0]        magnitude_o,
  output logic signed [rgm_pkg::AngBits-1:0] angle_o,
  output logic          result_undefined_o,
  output logic [rgm_pkg::AddrBits-1:0]       column_o,
  output logic [rgm_pkg::AddrBits-1:0]       row_o,
  output logic          frame_last_o
);

  localparam int VecBits = rgm_pkg::VecBits;
  localparam int ZBits   = rgm_pkg::ZBits;
  localparam int SumBits = rgm_pkg::SumBits;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_SUM,
    B_ITER,
    B_DONE
  } bstate_e;

  bstate_e                        state_q;
  rgm_pkg::win_t                  item_q;
  logic [2*rgm_pkg::DiffBits-1:0] p1_q, p2_q;
  logic [SumBits-1:0]             n_q, r_q;
  logic signed [VecBits-1:0]      x_q, y_q;
  logic signed [ZBits-1:0]        z_q, base_q;
  logic [rgm_pkg::StepBits-1:0]   cnt_q;
  logic                           out_valid_q;

  logic signed [VecBits-1:0]      xs, ys;
  logic [SumBits-1:0]             sbit, trial;
  logic [rgm_pkg::StepBits-1:0]   sk;
  logic signed [ZBits-1:0]        theta, t;
  logic signed [17:0]             q;
  logic                           zero_vec, out_free;

  assign q_pop_o     = (state_q == B_IDLE) && !q_empty_i;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign zero_vec    = (item_q.d1 == '0) && (item_q.d2 == '0);

  always_comb begin
    xs    = x_q >>> cnt_q;
    ys    = y_q >>> cnt_q;
    sk    = 5'(rgm_pkg::SqrtSteps - 1) - cnt_q;
    sbit  = SumBits'(1) << {sk, 1'b0};
    trial = r_q + sbit;
    theta = zero_vec ? '0 : base_q + z_q;
    t     = theta + ZBits'(1024);
    q     = 18'(t >>> 11) - rgm_pkg::QuarterPiQ13;
    if (q <= -rgm_pkg::PiQ13) q = q + rgm_pkg::TwoPiQ13;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      // in B_DONE a taken result is replaced below when the next one is ready
      if (out_valid_q && out_ready_i && (state_q != B_DONE)) out_valid_q <= 1'b0;
      case (state_q)
        B_IDLE: begin
          if (!q_empty_i) begin
            item_q  <= q_item_i;
            state_q <= q_item_i.und ? B_DONE : B_MUL;
          end
        end
        B_MUL: begin
          p1_q <= 34'($signed(item_q.d1) * $signed(item_q.d1));
          p2_q <= 34'($signed(item_q.d2) * $signed(item_q.d2));
          // vectors with negative x are turned by pi first
          if (item_q.d2 < 0) begin
            base_q <= (item_q.d1 >= 0) ? rgm_pkg::PiQ24 : -rgm_pkg::PiQ24;
            x_q    <= -(VecBits'(item_q.d2) <<< 14);
            y_q    <= -(VecBits'(item_q.d1) <<< 14);
          end else begin
            base_q <= '0;
            x_q    <= VecBits'(item_q.d2) <<< 14;
            y_q    <= VecBits'(item_q.d1) <<< 14;
          end
          z_q     <= '0;
          state_q <= B_SUM;
        end
        B_SUM: begin
          n_q     <= SumBits'(p1_q) + SumBits'(p2_q);
          r_q     <= '0;
          cnt_q   <= '0;
          state_q <= B_ITER;
        end
        B_ITER: begin
          if (y_q < 0) begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - rgm_pkg::atan_q24(cnt_q);
          end else begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + rgm_pkg::atan_q24(cnt_q);
          end
          if (cnt_q < 5'(rgm_pkg::SqrtSteps)) begin
            if (n_q >= trial) begin
              n_q <= n_q - trial;
              r_q <= (r_q >> 1) + sbit;
            end else begin
              r_q <= r_q >> 1;
            end
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'(rgm_pkg::CordicSteps - 1)) state_q <= B_DONE;
        end
        B_DONE: begin
          if (out_free) begin
            out_valid_q        <= 1'b1;
            result_undefined_o <= item_q.und;
            column_o           <= item_q.col;
            row_o              <= item_q.row;
            frame_last_o       <= item_q.last;
            if (item_q.und) begin
              magnitude_o <= '0;
              angle_o     <= '0;
            end else begin
              // remainder above root means round up
              magnitude_o <= rgm_pkg::MagBits'(n_q > r_q ? r_q + 1'b1 : r_q);
              angle_o     <= rgm_pkg::AngBits'(q);
            end
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/roberts_gradient_mag_angle.sv
// roberts_gradient_mag_angle: top level, configuration registers and the
// front, queue and back; depends on rgm_pkg, rgm_if and the rgm modules
//
//   channel   dir  handshake              payload
//   pix_in    in   valid/ready            sample, sample_undefined
//   res_out   out  valid/ready            magnitude, angle, result_undefined,
//                                         column, row, frame_last
//   cfg       in   cfg_we_i               cfg_index_i, cfg_data_i
//
// the front takes one pixel at a time (line store read, then write back); the back
// takes a defined window through pop, multiply, sum, 24 cordic steps with the square
// root alongside, and output, and an undefined one through pop and output
// a two-entry queue lets the front run ahead; border pixels need the front only
// reset clears counters, window pixels, queue and result valid; line store is not cleared
module roberts_gradient_mag_angle (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rgm_pix_if.sink                     pix_in,
  rgm_res_if.source                   res_out,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [rgm_pkg::DimBits-1:0] cfg_data_i
);

  rgm_pkg::dims_t dims_q;
  rgm_pkg::win_t  wr_item, rd_item;
  rgm_pkg::qctl_t qctl;
  logic           q_empty, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q.width  <= rgm_pkg::WidthReset;
      dims_q.height <= rgm_pkg::HeightReset;
    end else if (cfg_we_i) begin
      case (rgm_pkg::reg_idx_e'(cfg_index_i))
        rgm_pkg::REG_WIDTH:  dims_q.width  <= cfg_data_i;
        rgm_pkg::REG_HEIGHT: dims_q.height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rgm_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .dims_i             (dims_q),
    .in_valid_i         (pix_in.valid),
    .in_ready_o         (pix_in.ready),
    .sample_i           (pix_in.sample),
    .sample_undefined_i (pix_in.sample_undefined),
    .q_full_i           (qctl.full),
    .q_push_o           (qctl.push),
    .q_item_o           (wr_item)
  );

  rgm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (qctl),
    .full_o  (qctl.full),
    .item_i  (wr_item),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (rd_item)
  );

  rgm_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_empty_i          (q_empty),
    .q_pop_o            (q_pop),
    .q_item_i           (rd_item),
    .out_valid_o        (res_out.valid),
    .out_ready_i        (res_out.ready),
    .magnitude_o        (res_out.magnitude),
    .angle_o            (res_out.angle),
    .result_undefined_o (res_out.result_undefined),
    .column_o           (res_out.column),
    .row_o              (res_out.row),
    .frame_last_o       (res_out.frame_last)
  );

endmodule
